// ----- src/assert_macros.svh -----
// Assertion macros shared by the poll master modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SLPM_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the house clock and reset names.
`define SLPM_ASSERT(lbl, prop, msg) `SLPM_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- src/slpm_pkg.sv -----
// Package: types, codes and constants of the serial link poll master.
`default_nettype none

package slpm_pkg;

  localparam int unsigned REPLY_BYTES_DEF = 32;

  // Link command codes as sent in frame byte 5
  localparam logic [1:0] CMD_INFO = 2'd1;
  localparam logic [1:0] CMD_CTRL = 2'd2;
  localparam logic [1:0] CMD_NEW  = 2'd3;

  // Input transaction kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_RXWR  = 2'd2;

  // Frame framing bytes
  localparam logic [7:0] FRM_SOF0 = 8'hF7;
  localparam logic [7:0] FRM_SOF1 = 8'hF8;
  localparam logic [7:0] FRM_ADDR = 8'h01;
  localparam logic [7:0] FRM_EOF  = 8'hFD;

  localparam logic [7:0] NEW_VERSION_MIN = 8'd100;
  localparam logic [7:0] WAIT_TICKS_RST  = 8'd25;
  localparam logic [7:0] FAIL_LIMIT_RST  = 8'd15;

  // Reply buffer positions walked by the parser
  localparam logic [4:0] RPL_CMD_IDX  = 5'd5;
  localparam logic [4:0] RPL_LAST_IDX = 5'd21;

  typedef enum logic [2:0] {
    CFG_STARTUP_VOLT = 3'd0,
    CFG_RATING_VOLT  = 3'd1,
    CFG_RATING_F1    = 3'd2,
    CFG_RPM_SCALE    = 3'd3,
    CFG_RATED_RPM    = 3'd4,
    CFG_WAIT_TICKS   = 3'd5,
    CFG_FAIL_LIMIT   = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TX,
    S_PARSE,
    S_SINGLE
  } ctrl_state_e;

  typedef struct packed {
    logic take;
    logic rx_write;
    logic tx_start;
    logic tx_emit;
    logic parse_init;
    logic parse_run;
    logic timeout;
    logic wait_inc;
    logic emit_single;
  } slpm_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       receiving;
    logic       timeout;
    logic       out_free;
    logic       tx_last;
    logic       parse_done;
  } slpm_stat_t;

endpackage

`default_nettype wire

// ----- src/slpm_in_if.sv -----
// Input channel interface: valid/ready with the item fields.
`default_nettype none

interface slpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [4:0]  rx_index;
  logic [7:0]  rx_byte;
  logic        params_changed;
  logic [7:0]  user_req;
  logic [15:0] user_rpm;
  logic [7:0]  fan_speed;

  modport source (
    output valid, kind, rx_index, rx_byte, params_changed, user_req, user_rpm, fan_speed,
    input  ready
  );
  modport sink (
    input  valid, kind, rx_index, rx_byte, params_changed, user_req, user_rpm, fan_speed,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/slpm_out_if.sv -----
// Output channel interface: valid/ready with the result fields.
`default_nettype none

interface slpm_out_if;
  logic        valid;
  logic        ready;
  logic        has_byte;
  logic [7:0]  tx_byte;
  logic        last;
  logic        request_taken;
  logic        link_error;
  logic [7:0]  board_version;
  logic [15:0] machine_rpm;
  logic [15:0] step_count;
  logic [7:0]  motor_volt;
  logic [7:0]  motor_current;
  logic [15:0] fault_code;
  logic [7:0]  machine_status;

  modport source (
    output valid, has_byte, tx_byte, last, request_taken, link_error, board_version,
           machine_rpm, step_count, motor_volt, motor_current, fault_code, machine_status,
    input  ready
  );
  modport sink (
    input  valid, has_byte, tx_byte, last, request_taken, link_error, board_version,
           machine_rpm, step_count, motor_volt, motor_current, fault_code, machine_status,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/serial_link_poll_master.sv -----
// Top level of the serial link poll master: controller plus datapath.
// Transmit tick: first frame byte emitted from the TX state after decode, then one byte per cycle
//   while the output is free (8, 22 or 12 bytes); the next item is accepted only once the frame ends.
// Reply tick: reply buffer walked one byte per cycle through its single read
//   port, then a single result is emitted; other items go from decode to a single result.
// Reset is asynchronous, active low; no clearing pass, the reply buffer is not reset.
`default_nettype none

module serial_link_poll_master
  import slpm_pkg::*;
#(
  parameter int unsigned REPLY_BYTES = REPLY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  slpm_in_if.sink     in_chan_i,
  slpm_out_if.source  out_chan_o
);

  slpm_cmd_t  cmd;
  slpm_stat_t stat;
  logic       in_ready;

  // Controller: one transaction at a time, sequences transmit, parse and result
  slpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  assign in_chan_i.ready = in_ready;

  // Datapath: config regs, link counters, frame builder, reply buffer, result register
  slpm_dp #(
    .REPLY_BYTES (REPLY_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .kind_i           (in_chan_i.kind),
    .rx_index_i       (in_chan_i.rx_index),
    .rx_byte_i        (in_chan_i.rx_byte),
    .params_changed_i (in_chan_i.params_changed),
    .user_req_i       (in_chan_i.user_req),
    .user_rpm_i       (in_chan_i.user_rpm),
    .fan_speed_i      (in_chan_i.fan_speed),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_chan_o.ready),
    .out_valid_o      (out_chan_o.valid),
    .has_byte_o       (out_chan_o.has_byte),
    .tx_byte_o        (out_chan_o.tx_byte),
    .last_o           (out_chan_o.last),
    .request_taken_o  (out_chan_o.request_taken),
    .link_error_o     (out_chan_o.link_error),
    .board_version_o  (out_chan_o.board_version),
    .machine_rpm_o    (out_chan_o.machine_rpm),
    .step_count_o     (out_chan_o.step_count),
    .motor_volt_o     (out_chan_o.motor_volt),
    .motor_current_o  (out_chan_o.motor_current),
    .fault_code_o     (out_chan_o.fault_code),
    .machine_status_o (out_chan_o.machine_status)
  );

endmodule

`default_nettype wire

// ----- src/slpm_ctrl.sv -----
// Controller state machine of the poll master.
`default_nettype none
`include "assert_macros.svh"

module slpm_ctrl
  import slpm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  slpm_stat_t stat_i,
  output slpm_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.kind == KIND_RXWR) begin
          cmd_o.rx_write = 1'b1;
          state_d        = S_SINGLE;
        end else if (!stat_i.receiving) begin
          cmd_o.tx_start = 1'b1;
          state_d        = S_TX;
        end else if (stat_i.kind == KIND_REPLY) begin
          cmd_o.parse_init = 1'b1;
          state_d          = S_PARSE;
        end else if (stat_i.timeout) begin
          cmd_o.timeout = 1'b1;
          state_d       = S_SINGLE;
        end else begin
          cmd_o.wait_inc = 1'b1;
          state_d        = S_SINGLE;
        end
      end
      S_TX: begin
        if (stat_i.out_free) begin
          cmd_o.tx_emit = 1'b1;
          if (stat_i.tx_last) state_d = S_IDLE;
        end
      end
      S_PARSE: begin
        cmd_o.parse_run = 1'b1;
        if (stat_i.parse_done) state_d = S_SINGLE;
      end
      S_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `SLPM_ASSERT(a_take_decodes, cmd_o.take |=> state_q == S_DECODE, "accept not followed by decode")
  `SLPM_ASSERT(a_last_byte_idle, (state_q == S_TX && cmd_o.tx_emit && stat_i.tx_last) |=> state_q == S_IDLE, "frame end did not return to idle")

endmodule

`default_nettype wire

// ----- src/slpm_dp.sv -----
// Datapath: config, link state, frame builder, reply buffer, parser, result register.
`default_nettype none
`include "assert_macros.svh"

module slpm_dp
  import slpm_pkg::*;
#(
  parameter int unsigned REPLY_BYTES = REPLY_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic [1:0]  kind_i,
  input  logic [4:0]  rx_index_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        params_changed_i,
  input  logic [7:0]  user_req_i,
  input  logic [15:0] user_rpm_i,
  input  logic [7:0]  fan_speed_i,
  input  slpm_cmd_t   cmd_i,
  output slpm_stat_t  stat_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        has_byte_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic        request_taken_o,
  output logic        link_error_o,
  output logic [7:0]  board_version_o,
  output logic [15:0] machine_rpm_o,
  output logic [15:0] step_count_o,
  output logic [7:0]  motor_volt_o,
  output logic [7:0]  motor_current_o,
  output logic [15:0] fault_code_o,
  output logic [7:0]  machine_status_o
);

  localparam int unsigned AW = $clog2(REPLY_BYTES);

  // latched item
  logic [1:0]  kind_q;
  logic [4:0]  rx_idx_q;
  logic [7:0]  rx_byte_q;
  logic        pchg_q;
  logic [7:0]  ureq_q;
  logic [15:0] urpm_q;
  logic [7:0]  fan_q;

  // configuration
  logic [7:0]  startup_volt_q, rating_volt_q, rating_f1_q, wait_ticks_q, fail_limit_q;
  logic [31:0] rpm_scale_q;
  logic [15:0] rated_rpm_q;

  // link state
  logic        receiving_q, alarm_q;
  logic [1:0]  next_cmd_q, next_cmd_d;
  logic [7:0]  wait_cnt_q, fail_cnt_q;

  // status registers
  logic [7:0]  version_q, volt_q, current_q, status_q;
  logic [15:0] rpm_q, steps_q, fault_q;

  // transmit
  logic [1:0]  cmd_q;
  logic [4:0]  idx_q, frame_size;
  logic [7:0]  sum_q, body_byte, tx_byte_d;
  logic        tx_last, in_sum;

  // reply buffer and parser
  logic [7:0]  mem [REPLY_BYTES];
  logic [4:0]  rd_idx_q, rd_tag_q;
  logic        rd_vld_q;
  logic [7:0]  rd_data_q, rcmd_q;
  logic        parse_done, mem_we;

  // result register
  logic        out_valid_q, has_byte_q, last_q, taken_q, alarm_sn_q;
  logic [7:0]  tx_byte_q, version_sn_q, volt_sn_q, current_sn_q, status_sn_q;
  logic [15:0] rpm_sn_q, steps_sn_q, fault_sn_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q    <= kind_i;
      rx_idx_q  <= rx_index_i;
      rx_byte_q <= rx_byte_i;
      pchg_q    <= params_changed_i;
      ureq_q    <= user_req_i;
      urpm_q    <= user_rpm_i;
      fan_q     <= fan_speed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      startup_volt_q <= '0;
      rating_volt_q  <= '0;
      rating_f1_q    <= '0;
      rpm_scale_q    <= '0;
      rated_rpm_q    <= '0;
      wait_ticks_q   <= WAIT_TICKS_RST;
      fail_limit_q   <= FAIL_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_STARTUP_VOLT: startup_volt_q <= cfg_data_i[7:0];
        CFG_RATING_VOLT:  rating_volt_q  <= cfg_data_i[7:0];
        CFG_RATING_F1:    rating_f1_q    <= cfg_data_i[7:0];
        CFG_RPM_SCALE:    rpm_scale_q    <= cfg_data_i;
        CFG_RATED_RPM:    rated_rpm_q    <= cfg_data_i[15:0];
        CFG_WAIT_TICKS:   wait_ticks_q   <= cfg_data_i[7:0];
        CFG_FAIL_LIMIT:   fail_limit_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // frame builder
  assign next_cmd_d = pchg_q ? CMD_CTRL : next_cmd_q;

  always_comb begin
    unique case (cmd_q)
      CMD_CTRL: frame_size = 5'd22;
      CMD_NEW:  frame_size = 5'd12;
      default:  frame_size = 5'd8;
    endcase
  end

  always_comb begin
    body_byte = 8'h00;
    case (idx_q)
      5'd0:  body_byte = FRM_SOF0;
      5'd1:  body_byte = FRM_SOF1;
      5'd2:  body_byte = 8'(frame_size - 5'd4);
      5'd3:  body_byte = FRM_ADDR;
      5'd4:  body_byte = FRM_ADDR;
      5'd5:  body_byte = {6'b0, cmd_q};
      5'd6:  if (cmd_q != CMD_INFO) body_byte = ureq_q;
      5'd7:  if (cmd_q != CMD_INFO) body_byte = urpm_q[15:8];
      5'd8:  if (cmd_q != CMD_INFO) body_byte = urpm_q[7:0];
      5'd9:  if (cmd_q == CMD_NEW)  body_byte = fan_q;
      5'd10: if (cmd_q == CMD_CTRL) body_byte = startup_volt_q;
      5'd11: if (cmd_q == CMD_CTRL) body_byte = rating_volt_q;
      5'd13: if (cmd_q == CMD_CTRL) body_byte = rpm_scale_q[31:24];
      5'd14: if (cmd_q == CMD_CTRL) body_byte = rpm_scale_q[23:16];
      5'd15: if (cmd_q == CMD_CTRL) body_byte = rpm_scale_q[15:8];
      5'd16: if (cmd_q == CMD_CTRL) body_byte = rpm_scale_q[7:0];
      5'd17: if (cmd_q == CMD_CTRL) body_byte = rated_rpm_q[15:8];
      5'd18: if (cmd_q == CMD_CTRL) body_byte = rated_rpm_q[7:0];
      5'd19: if (cmd_q == CMD_CTRL) body_byte = rating_f1_q;
      default: body_byte = 8'h00;
    endcase
  end

  assign tx_last = (idx_q == 5'(frame_size - 5'd1));
  // checksum covers the length byte up to the last field byte
  assign in_sum  = (idx_q >= 5'd2) && (idx_q < 5'(frame_size - 5'd2));

  always_comb begin
    if (tx_last)                               tx_byte_d = FRM_EOF;
    else if (idx_q == 5'(frame_size - 5'd2))   tx_byte_d = sum_q;
    else                                       tx_byte_d = body_byte;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tx_start) begin
      cmd_q <= (next_cmd_d == CMD_CTRL || next_cmd_d == CMD_NEW) ? next_cmd_d : CMD_INFO;
      idx_q <= '0;
      sum_q <= '0;
    end else if (cmd_i.tx_emit) begin
      idx_q <= idx_q + 5'd1;
      if (in_sum) sum_q <= sum_q + body_byte;
    end
  end

  // reply buffer: one write port, one registered read port
  assign mem_we = cmd_i.rx_write && (32'(rx_idx_q) < REPLY_BYTES);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[AW'(rx_idx_q)] <= rx_byte_q;
    rd_data_q <= mem[AW'(rd_idx_q)];
    rd_tag_q  <= rd_idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.parse_init) begin
      rd_idx_q <= RPL_CMD_IDX;
    end else if (cmd_i.parse_run && rd_idx_q != RPL_LAST_IDX) begin
      rd_idx_q <= rd_idx_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.parse_run;
    end
  end

  assign parse_done = rd_vld_q && (rd_tag_q == RPL_LAST_IDX);

  // parser: one reply byte per cycle, dispatched on the reply command
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && rd_tag_q == RPL_CMD_IDX) rcmd_q <= rd_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= '0;
      rpm_q     <= '0;
      steps_q   <= '0;
      volt_q    <= '0;
      current_q <= '0;
      fault_q   <= '0;
      status_q  <= '0;
    end else if (rd_vld_q && rd_tag_q != RPL_CMD_IDX) begin
      if (rcmd_q == {6'b0, CMD_INFO}) begin
        if (rd_tag_q == 5'd8) version_q <= rd_data_q;
      end else if (rcmd_q == {6'b0, CMD_CTRL}) begin
        case (rd_tag_q)
          5'd7:  rpm_q[15:8]   <= rd_data_q;
          5'd8:  rpm_q[7:0]    <= rd_data_q;
          5'd11: steps_q[15:8] <= rd_data_q;
          5'd12: steps_q[7:0]  <= rd_data_q;
          5'd15: volt_q        <= rd_data_q;
          5'd18: fault_q[7:0]  <= rd_data_q;
          5'd19: fault_q[15:8] <= rd_data_q;
          5'd20: status_q      <= {7'b0, rd_data_q[0]};
          5'd21: current_q     <= rd_data_q;
          default: ;
        endcase
      end else if (rcmd_q == {6'b0, CMD_NEW}) begin
        case (rd_tag_q)
          5'd6:  status_q      <= rd_data_q;
          5'd7:  rpm_q[15:8]   <= rd_data_q;
          5'd8:  rpm_q[7:0]    <= rd_data_q;
          5'd9:  steps_q[15:8] <= rd_data_q;
          5'd10: steps_q[7:0]  <= rd_data_q;
          5'd11: volt_q        <= rd_data_q;
          5'd12: current_q     <= rd_data_q;
          5'd13: fault_q[7:0]  <= rd_data_q;
          5'd14: fault_q[15:8] <= rd_data_q;
          default: ;
        endcase
      end
    end
  end

  // link state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      next_cmd_q  <= CMD_INFO;
      wait_cnt_q  <= '0;
      fail_cnt_q  <= '0;
      alarm_q     <= 1'b0;
    end else if (cmd_i.tx_start) begin
      next_cmd_q  <= next_cmd_d;
      receiving_q <= 1'b1;
      wait_cnt_q  <= '0;
    end else if (parse_done) begin
      receiving_q <= 1'b0;
      wait_cnt_q  <= '0;
      fail_cnt_q  <= '0;
      alarm_q     <= 1'b0;
      if (rcmd_q == {6'b0, CMD_INFO}) begin
        next_cmd_q <= CMD_CTRL;
      end else if (rcmd_q == {6'b0, CMD_CTRL}) begin
        next_cmd_q <= (version_q >= NEW_VERSION_MIN) ? CMD_NEW : CMD_CTRL;
      end else if (rcmd_q == {6'b0, CMD_NEW}) begin
        next_cmd_q <= CMD_NEW;
      end else begin
        next_cmd_q <= CMD_INFO;
      end
    end else if (cmd_i.timeout) begin
      if (fail_cnt_q >= fail_limit_q) alarm_q <= 1'b1;
      else                            fail_cnt_q <= fail_cnt_q + 8'd1;
      receiving_q <= 1'b0;
      next_cmd_q  <= CMD_INFO;
      wait_cnt_q  <= '0;
    end else if (cmd_i.wait_inc) begin
      wait_cnt_q <= wait_cnt_q + 8'd1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tx_emit || cmd_i.emit_single) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tx_emit || cmd_i.emit_single) begin
      has_byte_q   <= cmd_i.tx_emit;
      tx_byte_q    <= cmd_i.tx_emit ? tx_byte_d : 8'h00;
      last_q       <= cmd_i.emit_single || tx_last;
      taken_q      <= cmd_i.tx_emit && (cmd_q != CMD_INFO);
      alarm_sn_q   <= alarm_q;
      version_sn_q <= version_q;
      rpm_sn_q     <= rpm_q;
      steps_sn_q   <= steps_q;
      volt_sn_q    <= volt_q;
      current_sn_q <= current_q;
      fault_sn_q   <= fault_q;
      status_sn_q  <= status_q;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.kind       = kind_q;
    stat_o.receiving  = receiving_q;
    stat_o.timeout    = (wait_cnt_q >= wait_ticks_q);
    stat_o.out_free   = !out_valid_q || out_ready_i;
    stat_o.tx_last    = tx_last;
    stat_o.parse_done = parse_done;
  end

  assign out_valid_o      = out_valid_q;
  assign has_byte_o       = has_byte_q;
  assign tx_byte_o        = tx_byte_q;
  assign last_o           = last_q;
  assign request_taken_o  = taken_q;
  assign link_error_o     = alarm_sn_q;
  assign board_version_o  = version_sn_q;
  assign machine_rpm_o    = rpm_sn_q;
  assign step_count_o     = steps_sn_q;
  assign motor_volt_o     = volt_sn_q;
  assign motor_current_o  = current_sn_q;
  assign fault_code_o     = fault_sn_q;
  assign machine_status_o = status_sn_q;

  `SLPM_ASSERT(a_tx_sets_rx, cmd_i.tx_start |=> receiving_q, "transmit did not enter receive state")
  `SLPM_ASSERT(a_reply_clears, parse_done |=> (wait_cnt_q == 8'd0 && fail_cnt_q == 8'd0 && !alarm_q), "reply did not clear link counters")
  `SLPM_ASSERT(a_alarm_on_timeout, $rose(alarm_q) |-> $past(cmd_i.timeout), "alarm raised without timeout")

endmodule

`default_nettype wire
